@@ rtl/sha1md_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1md_pkg
// Types, constants and helpers shared by the SHA-1 digest engine files.
// ----------------------------------------------------------------------------
package sha1md_pkg;

   localparam int WORD_W   = 32;
   localparam int BLK_WORDS = 16;
   localparam int NUM_H    = 5;
   localparam int ROUNDS   = 80;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] K_R0 = 32'h5A827999;
   localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_R3 = 32'hCA62C1D6;

   // block buffer word slots for the bit length
   localparam logic [3:0] LEN_HI_SLOT = 4'd14;
   localparam logic [3:0] LEN_LO_SLOT = 4'd15;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word0;
      logic [31:0] digest_word1;
      logic [31:0] digest_word2;
      logic [31:0] digest_word3;
      logic [31:0] digest_word4;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_ROUND,
      ST_ADD,
      ST_DONE
   } state_type;

   function automatic word_type init_word(input int idx);
      word_type w;
      case (idx)
         0:       w = 32'h67452301;
         1:       w = 32'hEFCDAB89;
         2:       w = 32'h98BADCFE;
         3:       w = 32'h10325476;
         default: w = 32'hC3D2E1F0;
      endcase
      return w;
   endfunction

endpackage

@@ rtl/sha1md_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1md_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sha1md_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sha1_message_digest.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_message_digest
// Streaming SHA-1 engine: one message byte per item, digest per message.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one item per handshake, carrying msg_byte, byte_valid and
//    end_of_message. An item with byte_valid low and end_of_message low
//    is taken and does nothing.
//  - rsp_*: one item per message, the five chaining words H0..H4.
//  - Bytes are taken while req_ready is high. Every 64th byte starts the
//    compression, 80 rounds at one round per cycle and then the chaining
//    add, during which req_ready is low.
//  - The block buffer sits in a 16 x 32 RAM; bytes gather in a word register
//    and go to the RAM a word at a time. Rounds 0..15 read the RAM one word
//    ahead, later rounds expand the schedule from a 16-word shift line.
//  - End of message: padding bytes go in one per cycle outside a compression,
//    the padding state then finds the length slot, ST_LEN_HI and ST_LEN_LO
//    write the bit length, then a compression (two if the length does not fit).
//  - The digest sits in an output register. New bytes are taken while it
//    waits; only the next digest waits for rsp_ready.
//  - Reset: initial chaining values, empty buffer, zero length, no result.
// ----------------------------------------------------------------------------
module sha1_message_digest (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sha1md_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sha1md_pkg::rsp_type rsp_data
);
   import sha1md_pkg::*;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;          // bytes held in the block
   word_type    word_ff, word_in;          // partial word being gathered
   logic [63:0] bits_ff, bits_in;          // message length in bits
   logic        fin_ff, fin_in;            // padding still to run
   logic        mark_ff, mark_in;          // 0x80 not yet placed
   logic        last_ff, last_in;          // block in flight is the final one
   logic [6:0]  round_ff, round_in;
   word_type    h_ff [NUM_H];
   word_type    h_in [NUM_H];
   word_type    rv_ff [NUM_H];
   word_type    rv_in [NUM_H];
   word_type    sched_ff [BLK_WORDS];      // [0] oldest, W[t-16]
   word_type    sched_in [BLK_WORDS];
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // RAM
   logic        ram_we;
   logic [3:0]  ram_waddr;
   word_type    ram_wdata;
   logic [3:0]  ram_raddr;
   word_type    ram_rdata;

   // byte insertion
   logic [7:0]  put_val;
   logic [4:0]  put_sh;
   word_type    word_new;

   // round datapath
   word_type    w_cur;
   word_type    w_exp;
   word_type    f_val;
   word_type    k_val;
   word_type    t_val;

   sha1md_ram #(
      .WIDTH (WORD_W),
      .DEPTH (BLK_WORDS)
   ) u_blk_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Next word is fetched one round ahead; address 0 is presented on the
   // cycle that starts a block.
   assign ram_raddr = (state_ff == ST_ROUND) ? (round_ff[3:0] + 4'd1) : 4'd0;

   assign put_val  = (state_ff == ST_PAD) ? (mark_ff ? PAD_MARK : 8'h00)
                                          : req_data.msg_byte;
   assign put_sh   = {~fill_ff[1:0], 3'b000};
   assign word_new = (fill_ff[1:0] == 2'd0) ? {put_val, 24'h000000}
                                            : (word_ff | ({24'h000000, put_val} << put_sh));

   // Message schedule and round function
   always_comb begin
      w_exp = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      w_exp = {w_exp[30:0], w_exp[31]};
      w_cur = (round_ff < 7'(BLK_WORDS)) ? ram_rdata : w_exp;
      if (round_ff inside {[7'd0:7'd19]}) begin
         f_val = (rv_ff[1] & rv_ff[2]) | (~rv_ff[1] & rv_ff[3]);
         k_val = K_R0;
      end else if (round_ff inside {[7'd20:7'd39]}) begin
         f_val = rv_ff[1] ^ rv_ff[2] ^ rv_ff[3];
         k_val = K_R1;
      end else if (round_ff inside {[7'd40:7'd59]}) begin
         f_val = (rv_ff[1] & rv_ff[2]) | (rv_ff[1] & rv_ff[3]) | (rv_ff[2] & rv_ff[3]);
         k_val = K_R2;
      end else begin
         f_val = rv_ff[1] ^ rv_ff[2] ^ rv_ff[3];
         k_val = K_R3;
      end
      t_val = {rv_ff[0][26:0], rv_ff[0][31:27]} + f_val + rv_ff[4] + k_val + w_cur;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      word_in      = word_ff;
      bits_in      = bits_ff;
      fin_in       = fin_ff;
      mark_in      = mark_ff;
      last_in      = last_ff;
      round_in     = round_ff;
      h_in         = h_ff;
      rv_in        = rv_ff;
      sched_in     = sched_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_waddr    = fill_ff[5:2];
      ram_wdata    = word_new;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fin_in  = req_data.end_of_message;
               mark_in = 1'b1;
               if (req_data.byte_valid) begin
                  bits_in = bits_ff + 64'd8;
                  word_in = word_new;
                  fill_in = fill_ff + 6'd1;
                  ram_we  = (fill_ff[1:0] == 2'd3);
               end
               if (req_data.byte_valid && (fill_ff == 6'd63)) begin
                  rv_in    = h_ff;
                  round_in = '0;
                  state_in = ST_ROUND;
               end else if (req_data.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (!mark_ff && (fill_ff == 6'd56)) begin
               state_in = ST_LEN_HI;
            end else begin
               mark_in = 1'b0;
               word_in = word_new;
               fill_in = fill_ff + 6'd1;
               ram_we  = (fill_ff[1:0] == 2'd3);
               if (fill_ff == 6'd63) begin
                  rv_in    = h_ff;
                  round_in = '0;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_LEN_HI: begin
            ram_we    = 1'b1;
            ram_waddr = LEN_HI_SLOT;
            ram_wdata = bits_ff[63:32];
            state_in  = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            ram_we    = 1'b1;
            ram_waddr = LEN_LO_SLOT;
            ram_wdata = bits_ff[31:0];
            last_in   = 1'b1;
            rv_in     = h_ff;
            round_in  = '0;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            for (int i = 0; i < BLK_WORDS - 1; i++) begin
               sched_in[i] = sched_ff[i+1];
            end
            sched_in[BLK_WORDS-1] = w_cur;
            rv_in[4] = rv_ff[3];
            rv_in[3] = rv_ff[2];
            rv_in[2] = {rv_ff[1][1:0], rv_ff[1][31:2]};
            rv_in[1] = rv_ff[0];
            rv_in[0] = t_val;
            round_in = round_ff + 7'd1;
            if (round_ff == 7'(ROUNDS - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < NUM_H; i++) begin
               h_in[i] = h_ff[i] + rv_ff[i];
            end
            if (last_ff) begin
               state_in = ST_DONE;
            end else if (fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.digest_word0 = h_ff[0];
               rsp_data_in.digest_word1 = h_ff[1];
               rsp_data_in.digest_word2 = h_ff[2];
               rsp_data_in.digest_word3 = h_ff[3];
               rsp_data_in.digest_word4 = h_ff[4];
               for (int i = 0; i < NUM_H; i++) begin
                  h_in[i] = init_word(i);
               end
               fill_in  = '0;
               bits_in  = '0;
               fin_in   = 1'b0;
               last_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         bits_ff      <= '0;
         fin_ff       <= 1'b0;
         mark_ff      <= 1'b0;
         last_ff      <= 1'b0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_H; i++) begin
            h_ff[i] <= init_word(i);
         end
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         fin_ff       <= fin_in;
         mark_ff      <= mark_in;
         last_ff      <= last_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         h_ff         <= h_in;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      rv_ff       <= rv_in;
      sched_ff    <= sched_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/sha1md_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1md_checker
// Port level checks for the SHA-1 digest engine, bound to the top level.
// ----------------------------------------------------------------------------
module sha1md_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input sha1md_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input sha1md_pkg::rsp_type rsp_data
);
   import sha1md_pkg::*;

   // a pending digest holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("digest dropped or changed while stalled");

   // the input closes right after the last item, for padding or a compression
   a_eom_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.end_of_message |=> !req_ready)
      else $error("input still open right after end of message");

   // an empty, non-final item leaves the engine open
   a_nop_open: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.byte_valid && !req_data.end_of_message
      |=> req_ready)
      else $error("empty item stalled the input");

   // a new digest only appears out of a busy phase
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("digest appeared while input was open");

   // clean state leaving reset
   a_reset_state: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("engine not idle after reset");

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stand-alone check of the streaming SHA-1 engine. Messages of random length
// are fed one byte per item, with no-op items mixed in. A model of the engine
// held here gives the digest expected for each message, and every digest that
// comes back is compared word by word. The run steps through phases of sender
// gaps and receiver stalls, plus one long receiver hold-off that backs up the
// engine.
// ----------------------------------------------------------------------------
module tb;
   import sha1md_pkg::*;

   // -------------------------------------------------------------------------
   // Digest tracker: a byte-level SHA-1 model plus the queue of digests
   // the engine still owes us.
   // -------------------------------------------------------------------------
   class sha1_digest_tracker;
      localparam logic [7:0] PAD_BYTE = 8'h80;

      word_type    chain[5];
      word_type    blk[16];
      int unsigned fill;
      logic [63:0] bit_len;
      rsp_type     expected_digests[$];
      int          mismatches;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         chain[0] = 32'h67452301;
         chain[1] = 32'hEFCDAB89;
         chain[2] = 32'h98BADCFE;
         chain[3] = 32'h10325476;
         chain[4] = 32'hC3D2E1F0;
         fill     = 0;
         bit_len  = '0;
      endfunction

      function word_type rol(word_type v, int k);
         return (v << k) | (v >> (32 - k));
      endfunction

      // 80-round compression of the current block into the chaining words
      function void compress();
         word_type w[80];
         word_type a, b, c, d, e, f, k, t;
         for (int r = 0; r < 16; r++) w[r] = blk[r];
         for (int r = 16; r < 80; r++)
            w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
         for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
               f = (b & c) | (~b & d);          k = 32'h5A827999;
            end else if (r < 40) begin
               f = b ^ c ^ d;                   k = 32'h6ED9EBA1;
            end else if (r < 60) begin
               f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
               f = b ^ c ^ d;                   k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
      endfunction

      // big-endian byte packing; first byte of a word clears the word
      function void push_byte(logic [7:0] b);
         int unsigned idx, sh;
         idx = fill >> 2;
         sh  = (3 - (fill & 3)) * 8;
         if ((fill & 3) == 0) blk[idx] = word_type'(b) << sh;
         else                 blk[idx] |= word_type'(b) << sh;
         fill++;
         if (fill == 64) begin
            compress();
            fill = 0;
         end
      endfunction

      function void absorb_item(req_type it);
         logic [63:0] len;
         rsp_type     dig;
         if (it.byte_valid) begin
            bit_len += 64'd8;
            push_byte(it.msg_byte);
         end
         if (!it.end_of_message) return;
         len = bit_len;
         push_byte(PAD_BYTE);
         // length does not fit: pad out this block and start a fresh one
         if (fill > 56) while (fill != 0) push_byte(8'h00);
         while (fill < 56) push_byte(8'h00);
         blk[14] = len[63:32];
         blk[15] = len[31:0];
         compress();
         dig.digest_word0 = chain[0];
         dig.digest_word1 = chain[1];
         dig.digest_word2 = chain[2];
         dig.digest_word3 = chain[3];
         dig.digest_word4 = chain[4];
         expected_digests.push_back(dig);
         restart();
      endfunction

      function void compare_word(string label, word_type exp_w, word_type got_w);
         if (got_w !== exp_w) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %08h, actual %08h",
                     $time, label, exp_w, got_w);
         end
      endfunction

      function void check_digest(rsp_type got);
         rsp_type exp_d;
         if (expected_digests.size() == 0) begin
            mismatches++;
            $display("%0t: digest with none expected, expected nothing, actual %h",
                     $time, got);
            return;
         end
         exp_d = expected_digests.pop_front();
         compare_word("digest_word0", exp_d.digest_word0, got.digest_word0);
         compare_word("digest_word1", exp_d.digest_word1, got.digest_word1);
         compare_word("digest_word2", exp_d.digest_word2, got.digest_word2);
         compare_word("digest_word3", exp_d.digest_word3, got.digest_word3);
         compare_word("digest_word4", exp_d.digest_word4, got.digest_word4);
      endfunction

      function int pending();
         return expected_digests.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Run parameters
   // -------------------------------------------------------------------------
   // The slowest run has ~1550 items, up to two compressions per message,
   // 65% gaps and stalls, plus the hold-off. The limit leaves a wide margin.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 2500;  // long receiver hold-off
   localparam int DRAIN_CYCLES = 300;   // wait after the last expected digest

   // -------------------------------------------------------------------------
   // Signals
   // -------------------------------------------------------------------------
   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   sha1_digest_tracker tracker = new();

   int  cycle_count   = 0;
   int  sent_items    = 0;   // counts items that carry a byte or end a message
   int  send_idle_pct = 0;   // only the sender reads this
   int  rsp_stall_pct = 0;
   bit  pressure_on   = 1'b0;
   bit  pressure_done = 1'b0;

   sha1_message_digest dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // -------------------------------------------------------------------------
   // Monitors: both sample pre-edge values, so they see exactly what the
   // engine saw at that edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) tracker.absorb_item(req_data);
      if (!reset && rsp_valid && rsp_ready) tracker.check_digest(rsp_data);
   end

   // -------------------------------------------------------------------------
   // Receiver: random stalls per phase. Once, when the pressure phase begins,
   // ready is held low for a long count so the output register fills, the
   // next digest backs up and the engine stops taking bytes.
   // -------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (pressure_on && !pressure_done) begin
            pressure_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Sender
   // -------------------------------------------------------------------------
   // Returns in the time step of the accepting edge, so the next call may
   // keep valid high straight on, with no idle gap.
   task automatic send_item(input req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      if (it.byte_valid || it.end_of_message) sent_items++;
   endtask

   task automatic send_noop();
      req_type it;
      it.msg_byte       = 8'($urandom_range(255));
      it.byte_valid     = 1'b0;
      it.end_of_message = 1'b0;
      send_item(it);
   endtask

   // One message of len bytes; the last byte rides on the end item half the
   // time, otherwise a byte-less end item closes the message.
   task automatic send_message(input int len, input bit with_noise);
      req_type it;
      bit      ride;
      ride = (len > 0) && ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
         if (with_noise && $urandom_range(19) == 0) send_noop();
         it.msg_byte       = 8'($urandom_range(255));
         it.byte_valid     = 1'b1;
         it.end_of_message = ride && (i == len - 1);
         send_item(it);
      end
      if (!ride) begin
         it.msg_byte       = 8'($urandom_range(255));
         it.byte_valid     = 1'b0;
         it.end_of_message = 1'b1;
         send_item(it);
      end
   endtask

   // Mostly short messages, a good share on the padding and block edges
   // (length just fits, just misses, exact blocks), a few long ones.
   function automatic int pick_length();
      int sel;
      sel = $urandom_range(99);
      if (sel < 60) return $urandom_range(40);
      if (sel < 88) begin
         case ($urandom_range(9))
            0:       return 55;
            1:       return 56;
            2:       return 57;
            3:       return 63;
            4:       return 64;
            5:       return 65;
            6:       return 119;
            7:       return 120;
            8:       return 127;
            default: return 128;
         endcase
      end
      return $urandom_range(41, 200);
   endfunction

   task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
      int target;
      target        = sent_items + n_items;
      send_idle_pct = idle_pct;
      rsp_stall_pct <= stall_pct;
      while (sent_items < target) begin
         if ($urandom_range(9) == 0) send_noop();
         send_message(pick_length(), 1'b1);
      end
   endtask

   task automatic send_directed(input logic [7:0] b, input logic bv, input logic eom);
      req_type it;
      it.msg_byte       = b;
      it.byte_valid     = bv;
      it.end_of_message = eom;
      send_item(it);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, lone no-op, "abc" with the last byte on the
      // end item, all-ones and all-zero bytes, a no-op inside a message
      send_directed(8'h00, 1'b0, 1'b1);
      send_directed(8'hA5, 1'b0, 1'b0);
      send_directed(8'h61, 1'b1, 1'b0);
      send_directed(8'h62, 1'b1, 1'b0);
      send_directed(8'h63, 1'b1, 1'b1);
      send_directed(8'hFF, 1'b1, 1'b1);
      send_directed(8'h00, 1'b1, 1'b0);
      send_directed(8'h5A, 1'b0, 1'b1);
      send_directed(8'h12, 1'b1, 1'b0);
      send_directed(8'h34, 1'b0, 1'b0);
      send_directed(8'h56, 1'b1, 1'b1);

      // length just fits, no longer fits, and one full block closed by a
      // byte-less end item
      send_message(55, 1'b0);
      send_message(56, 1'b0);
      send_directed(8'hC3, 1'b1, 1'b0);
      repeat (63) send_directed(8'($urandom_range(255)), 1'b1, 1'b0);
      send_directed(8'h3C, 1'b0, 1'b1);

      run_phase(0,  0,  380);
      run_phase(65, 0,  340);
      run_phase(0,  65, 320);
      run_phase(32, 32, 300);

      // pressure: a stream of short messages while the receiver holds off
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      pressure_on   <= 1'b1;
      for (int m = 0; m < 20; m++) send_message($urandom_range(6), 1'b0);

      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout, %0d digests outstanding", $time, tracker.pending());
      $display("Regression FAIL");
      $finish;
   end

endmodule
